### hdl/ascii_integer_parser_assert.svh
// ----------------------------------------------------------------------------
// ascii_integer_parser assertion macros
// Short forms for the concurrent checks of the parser.
// ----------------------------------------------------------------------------
`ifndef ASCII_INTEGER_PARSER_ASSERT_SVH
`define ASCII_INTEGER_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AIP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ascii_integer_parser: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define AIP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ascii_integer_parser: check failed");

`endif

### hdl/aip_pkg.sv
// ----------------------------------------------------------------------------
// aip_pkg
// Types and constants shared by the ASCII integer parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aip_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned CHAR_W  = 8;

    // Configuration register indexes
    localparam logic CFG_HEX_MODE    = 1'b0;
    localparam logic CFG_SIGNED_MODE = 1'b1;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_DIG_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIG_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_F = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LOW_X = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    // Result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last_char;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] parsed_value;
        logic               parse_status;
    } out_item_t;

endpackage

### hdl/ascii_integer_parser.sv
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Parses a decimal or hex ASCII number, one character per item, into a
// 64-bit value and a status on the last character.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake             | Payload
// s_       | in        | s_valid / s_ready     | in_item_t  (text_char, last_char)
// m_       | out       | m_valid / m_ready     | out_item_t (parsed_value, parse_status)
// cfg_     | in        | cfg_we                | cfg_index, cfg_wdata
//
// One character per cycle sustained, except while a held result stalls a last
// character; a result passes the input register, then the result register.
// Multiply-by-base and add are combinational; the negated value is kept in a
// parallel accumulator so the final sign needs no extra adder.
// Reset (aresetn low, synchronous) clears the number state and config.
// A result held by m_ready low stalls only last characters; others proceed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ascii_integer_parser_assert.svh"

module ascii_integer_parser
    import aip_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic      cfg_wdata,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic hex_mode_reg;
    logic signed_mode_reg;

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;

    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [VALUE_W-1:0] nacc_reg, nacc_next;
    logic [1:0]         pos_reg, pos_next;
    logic               sign_reg, sign_next;
    logic               neg_reg, neg_next;
    logic               err_reg, err_next;
    logic               zero_reg, zero_next;
    logic               pend_reg, pend_next;

    logic      m_valid_reg;
    out_item_t m_item_reg;

    logic       out_free;
    logic       advance;
    logic       is_digit;
    logic [3:0] dval;
    logic       first;
    logic       status;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    // Digit decode
    always_comb begin
        is_digit = 1'b0;
        dval     = 4'd0;
        case (in_char_reg) inside
            [CH_DIG_0:CH_DIG_9]: begin
                is_digit = 1'b1;
                dval     = 4'(in_char_reg - CH_DIG_0);
            end
            [CH_LOW_A:CH_LOW_F]: begin
                is_digit = hex_mode_reg;
                dval     = 4'(in_char_reg - CH_LOW_A + 8'd10);
            end
            [CH_UP_A:CH_UP_F]: begin
                is_digit = hex_mode_reg;
                dval     = 4'(in_char_reg - CH_UP_A + 8'd10);
            end
            default: begin
                is_digit = 1'b0;
                dval     = 4'd0;
            end
        endcase
    end

    // Per-character state update
    always_comb begin
        acc_next  = acc_reg;
        nacc_next = nacc_reg;
        pos_next  = pos_reg;
        sign_next = sign_reg;
        neg_next  = neg_reg;
        err_next  = err_reg;
        zero_next = zero_reg;
        pend_next = pend_reg;
        first     = !sign_reg && (pos_reg == 2'd0);
        if (!err_reg) begin
            if (first && ((in_char_reg == CH_PLUS) ||
                          ((in_char_reg == CH_MINUS) && signed_mode_reg))) begin
                sign_next = 1'b1;
                neg_next  = (in_char_reg == CH_MINUS);
                pend_next = 1'b1;
            end else if (hex_mode_reg && (pos_reg == 2'd1) && zero_reg &&
                         ((in_char_reg == CH_LOW_X) || (in_char_reg == CH_UP_X))) begin
                pos_next  = 2'd2;
                zero_next = 1'b0;
                pend_next = 1'b1;
            end else if (is_digit) begin
                if (hex_mode_reg) begin
                    acc_next  = (acc_reg << 4) + VALUE_W'(dval);
                    nacc_next = (nacc_reg << 4) - VALUE_W'(dval);
                end else begin
                    acc_next  = (acc_reg << 3) + (acc_reg << 1) + VALUE_W'(dval);
                    nacc_next = (nacc_reg << 3) + (nacc_reg << 1) - VALUE_W'(dval);
                end
                zero_next = (pos_reg == 2'd0) && (in_char_reg == CH_DIG_0);
                if (pos_reg != 2'd2) begin
                    pos_next = pos_reg + 2'd1;
                end
                pend_next = 1'b0;
            end else begin
                err_next = 1'b1;
            end
        end
        status = (err_next || pend_next) ? STATUS_INVALID : STATUS_OK;
    end

    // Configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hex_mode_reg    <= 1'b0;
            signed_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_HEX_MODE:    hex_mode_reg    <= cfg_wdata;
                CFG_SIGNED_MODE: signed_mode_reg <= cfg_wdata;
                default:         hex_mode_reg    <= hex_mode_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_item.text_char;
            in_last_reg <= s_item.last_char;
        end
    end

    // Number state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            nacc_reg <= '0;
            pos_reg  <= 2'd0;
            sign_reg <= 1'b0;
            neg_reg  <= 1'b0;
            err_reg  <= 1'b0;
            zero_reg <= 1'b0;
            pend_reg <= 1'b0;
        end else if (advance) begin
            if (in_last_reg) begin
                acc_reg  <= '0;
                nacc_reg <= '0;
                pos_reg  <= 2'd0;
                sign_reg <= 1'b0;
                neg_reg  <= 1'b0;
                err_reg  <= 1'b0;
                zero_reg <= 1'b0;
                pend_reg <= 1'b0;
            end else begin
                acc_reg  <= acc_next;
                nacc_reg <= nacc_next;
                pos_reg  <= pos_next;
                sign_reg <= sign_next;
                neg_reg  <= neg_next;
                err_reg  <= err_next;
                zero_reg <= zero_next;
                pend_reg <= pend_next;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            m_item_reg.parse_status <= status;
            if (status == STATUS_INVALID) begin
                m_item_reg.parsed_value <= '0;
            end else begin
                m_item_reg.parsed_value <= neg_next ? nacc_next : acc_next;
            end
        end
    end

    `AIP_ASSERT_IMP(a_neg_tracks, aclk, aresetn, 1'b1, nacc_reg == (VALUE_W'(0) - acc_reg))
    `AIP_ASSERT_IMP(a_invalid_zero, aclk, aresetn,
                    m_valid_reg && m_item_reg.parse_status, m_item_reg.parsed_value == '0)
    `AIP_ASSERT_NEXT(a_last_gives_result, aclk, aresetn, advance && in_last_reg, m_valid_reg)
    `AIP_ASSERT_IMP(a_stall_only_full, aclk, aresetn,
                    !s_ready, in_valid_reg && in_last_reg && !out_free)

endmodule
